/* rtl/complex_arithmetic_unit_defines.svh */
// ----------------------------------------------------------------------------
// Complex arithmetic unit assertion macros
// Shared property shapes for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define CAU_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("complex_arithmetic_unit check failed");

// Condition that must never hold outside reset
`define CAU_ASSERT_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("complex_arithmetic_unit check failed");

`endif

/* rtl/cau_pkg.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Widths, operation codes, transfer types and the saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

   localparam int DATA_WIDTH    = 32;
   localparam int FRACTION_BITS = 16;
   localparam int PROD_WIDTH    = 2 * DATA_WIDTH;
   localparam int SUM_WIDTH     = PROD_WIDTH + 1;
   localparam int NUM_WIDTH     = PROD_WIDTH + FRACTION_BITS;
   localparam int REM_WIDTH     = 3 * DATA_WIDTH + FRACTION_BITS;
   localparam int DIV_LATENCY   = DATA_WIDTH + 1;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef struct packed {
      op_type                        operation;
      logic signed [DATA_WIDTH-1:0] left_real;
      logic signed [DATA_WIDTH-1:0] left_imag;
      logic signed [DATA_WIDTH-1:0] right_real;
      logic signed [DATA_WIDTH-1:0] right_imag;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] result_real;
      logic signed [DATA_WIDTH-1:0] result_imag;
      logic                         divide_by_zero;
      logic                         saturated;
   } rsp_type;

   typedef struct packed {
      logic                  sat;
      logic [DATA_WIDTH-1:0] value;
   } clip_type;

   // Clip a sign and magnitude to the signed data range
   function automatic clip_type clip_part(input logic neg, input logic big,
                                          input logic [DATA_WIDTH-1:0] mag);
      logic [DATA_WIDTH-1:0] lim;
      logic [DATA_WIDTH-1:0] m;
      clip_type              r;
      lim = neg ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
      m   = mag;
      r.sat = 1'b0;
      if (big || (mag > lim)) begin
         m     = lim;
         r.sat = 1'b1;
      end
      r.value = neg ? (~m + 1'b1) : m;
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/cau_divider.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit divider
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_divider (
   input  wire logic                             clock,
   input  wire logic [cau_pkg::NUM_WIDTH-1:0]    num,
   input  wire logic [cau_pkg::PROD_WIDTH-1:0]   den,
   output logic      [cau_pkg::DATA_WIDTH-1:0]   quo,
   output logic                                  ovf
);
   import cau_pkg::*;

   localparam int QB = DATA_WIDTH;

   logic [REM_WIDTH-1:0]  rem_ff [0:QB];
   logic [PROD_WIDTH-1:0] den_ff [0:QB];
   logic [QB-1:0]         quo_ff [0:QB];
   logic                  ovf_ff [0:QB];

   // Entry: flag quotients that do not fit the data width
   always_ff @(posedge clock) begin
      rem_ff[0] <= REM_WIDTH'(num);
      den_ff[0] <= den;
      quo_ff[0] <= '0;
      ovf_ff[0] <= REM_WIDTH'(num) >= {REM_WIDTH'(den), {QB{1'b0}}};
   end

   // One quotient bit per stage, most significant first
   for (genvar k = 0; k < QB; k++) begin : g_stage
      logic [REM_WIDTH-1:0] shifted;
      logic                 ge;
      assign shifted = REM_WIDTH'(den_ff[k]) << (QB - 1 - k);
      assign ge      = rem_ff[k] >= shifted;
      always_ff @(posedge clock) begin
         rem_ff[k+1] <= ge ? (rem_ff[k] - shifted) : rem_ff[k];
         den_ff[k+1] <= den_ff[k];
         quo_ff[k+1] <= {quo_ff[k][QB-2:0], ge};
         ovf_ff[k+1] <= ovf_ff[k];
      end
   end

   assign quo = quo_ff[QB];
   assign ovf = ovf_ff[QB];

endmodule

`default_nettype wire

/* rtl/complex_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply or divide two Q16.16 complex operands, saturated.
// ----------------------------------------------------------------------------
// Usage: raise start with an operation and two complex operands on req_data.
// busy stays low, so a transfer happens at every clock edge with start high;
// a new item may enter every cycle. Each item yields exactly one result on
// rsp_data, marked by rsp_valid for one cycle, in order. The path runs
// through three stages of multiply, sum and magnitude, the divider with
// one stage per quotient bit (32) plus its overflow check, and the output
// clip register. Every operation takes the same path length, so results
// never reorder.
// Division by a zero divisor returns zero with divide_by_zero set. Parts
// that overflow are clipped and flagged with saturated.
// Reset clears all valid bits; items in flight are dropped. The receiver
// cannot stall: results must be taken in the cycle they appear.
// ----------------------------------------------------------------------------
`default_nettype none
`include "complex_arithmetic_unit_defines.svh"

module complex_arithmetic_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire cau_pkg::req_type req_data,
   output logic                  rsp_valid,
   output cau_pkg::rsp_type      rsp_data
);
   import cau_pkg::*;

   localparam int DW  = DATA_WIDTH;
   localparam int LAT = DIV_LATENCY + 4;

   typedef struct packed {
      op_type          op;
      logic            dz;
      logic [1:0]      neg;
      logic [1:0]      big;
      logic [DW-1:0]   mag_re;
      logic [DW-1:0]   mag_im;
   } tag_type;

   // Stage 1: products and plain sums
   logic                        v1_ff;
   op_type                      op1_ff;
   logic signed [PROD_WIDTH-1:0] ac_ff, bd_ff, ad_ff, bc_ff, cc_ff, dd_ff;
   logic signed [DW:0]          asum_ff [2];

   // Stage 2: combined sums
   logic                        v2_ff;
   op_type                      op2_ff;
   logic signed [SUM_WIDTH-1:0] msum_ff [2];
   logic signed [SUM_WIDTH-1:0] dsum_ff [2];
   logic signed [DW:0]          asum2_ff [2];
   logic [PROD_WIDTH-1:0]       den2_ff;

   // Stage 3: magnitudes
   logic                        v3_ff;
   tag_type                     tag3_ff;
   logic [NUM_WIDTH-1:0]        num_ff [2];
   logic [PROD_WIDTH-1:0]       den3_ff;

   // Divider alignment
   logic [DIV_LATENCY-1:0]      vd_ff;
   tag_type                     tagd_ff [DIV_LATENCY];
   logic [DW-1:0]               quo [2];
   logic                        ovf [2];

   logic                        rsp_valid_ff;
   rsp_type                     rsp_data_ff;
   logic                        accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Stage 1: multiply, and add or subtract
   always_ff @(posedge clock) begin
      ac_ff      <= req_data.left_real * req_data.right_real;
      bd_ff      <= req_data.left_imag * req_data.right_imag;
      ad_ff      <= req_data.left_real * req_data.right_imag;
      bc_ff      <= req_data.left_imag * req_data.right_real;
      cc_ff      <= req_data.right_real * req_data.right_real;
      dd_ff      <= req_data.right_imag * req_data.right_imag;
      op1_ff     <= req_data.operation;
      if (req_data.operation == OP_SUB) begin
         asum_ff[0] <= (DW+1)'(req_data.left_real) - (DW+1)'(req_data.right_real);
         asum_ff[1] <= (DW+1)'(req_data.left_imag) - (DW+1)'(req_data.right_imag);
      end else begin
         asum_ff[0] <= (DW+1)'(req_data.left_real) + (DW+1)'(req_data.right_real);
         asum_ff[1] <= (DW+1)'(req_data.left_imag) + (DW+1)'(req_data.right_imag);
      end
   end

   // Stage 2: form the product and quotient numerators and the divisor
   always_ff @(posedge clock) begin
      msum_ff[0]  <= SUM_WIDTH'(ac_ff) - SUM_WIDTH'(bd_ff);
      msum_ff[1]  <= SUM_WIDTH'(ad_ff) + SUM_WIDTH'(bc_ff);
      dsum_ff[0]  <= SUM_WIDTH'(ac_ff) + SUM_WIDTH'(bd_ff);
      dsum_ff[1]  <= SUM_WIDTH'(bc_ff) - SUM_WIDTH'(ad_ff);
      den2_ff     <= PROD_WIDTH'(cc_ff) + PROD_WIDTH'(dd_ff);
      asum2_ff[0] <= asum_ff[0];
      asum2_ff[1] <= asum_ff[1];
      op2_ff      <= op1_ff;
   end

   // Stage 3: split each part into sign and magnitude
   tag_type tag3_in;
   logic [NUM_WIDTH-1:0] num_in [2];

   for (genvar p = 0; p < 2; p++) begin : g_part
      logic [SUM_WIDTH-1:0] sel;
      logic [SUM_WIDTH-1:0] mag_full;
      logic [SUM_WIDTH-1:0] mag_shift;
      logic [DW:0]          amag;
      logic                 neg;
      logic                 big;
      logic [DW-1:0]        mag;

      always_comb begin
         sel       = (op2_ff == OP_DIV) ? dsum_ff[p] : msum_ff[p];
         mag_full  = sel[SUM_WIDTH-1] ? (~sel + 1'b1) : sel;
         mag_shift = mag_full >> FRACTION_BITS;
         amag      = asum2_ff[p][DW] ? (~asum2_ff[p] + 1'b1) : asum2_ff[p];
         num_in[p] = {mag_full[PROD_WIDTH-1:0], {FRACTION_BITS{1'b0}}};
         case (op2_ff)
            OP_ADD, OP_SUB: begin
               neg = asum2_ff[p][DW];
               big = amag[DW];
               mag = amag[DW-1:0];
            end
            default: begin
               neg = sel[SUM_WIDTH-1];
               big = |mag_shift[SUM_WIDTH-1:DW];
               mag = mag_shift[DW-1:0];
            end
         endcase
      end

      assign tag3_in.neg[p] = neg;
      assign tag3_in.big[p] = big;
   end

   assign tag3_in.op     = op2_ff;
   assign tag3_in.dz     = (den2_ff == '0);
   assign tag3_in.mag_re = g_part[0].mag;
   assign tag3_in.mag_im = g_part[1].mag;

   always_ff @(posedge clock) begin
      tag3_ff   <= tag3_in;
      num_ff[0] <= num_in[0];
      num_ff[1] <= num_in[1];
      den3_ff   <= den2_ff;
   end

   // Quotient pipelines for both parts
   cau_divider u_div_re (
      .clock (clock),
      .num   (num_ff[0]),
      .den   (den3_ff),
      .quo   (quo[0]),
      .ovf   (ovf[0])
   );

   cau_divider u_div_im (
      .clock (clock),
      .num   (num_ff[1]),
      .den   (den3_ff),
      .quo   (quo[1]),
      .ovf   (ovf[1])
   );

   // Hold sideband in step with the divider
   always_ff @(posedge clock) begin
      tagd_ff[0] <= tag3_ff;
      for (int k = 1; k < DIV_LATENCY; k++) begin
         tagd_ff[k] <= tagd_ff[k-1];
      end
   end

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         vd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= accept;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         vd_ff        <= {vd_ff[DIV_LATENCY-2:0], v3_ff};
         rsp_valid_ff <= vd_ff[DIV_LATENCY-1];
      end
   end

   // Output: select magnitude, clip and register
   tag_type  tag_out;
   clip_type clip_re, clip_im;
   rsp_type  rsp_in;

   always_comb begin
      tag_out = tagd_ff[DIV_LATENCY-1];
      if (tag_out.op == OP_DIV) begin
         clip_re = clip_part(tag_out.neg[0], ovf[0], quo[0]);
         clip_im = clip_part(tag_out.neg[1], ovf[1], quo[1]);
      end else begin
         clip_re = clip_part(tag_out.neg[0], tag_out.big[0], tag_out.mag_re);
         clip_im = clip_part(tag_out.neg[1], tag_out.big[1], tag_out.mag_im);
      end
      if ((tag_out.op == OP_DIV) && tag_out.dz) begin
         rsp_in.result_real    = '0;
         rsp_in.result_imag    = '0;
         rsp_in.divide_by_zero = 1'b1;
         rsp_in.saturated      = 1'b0;
      end else begin
         rsp_in.result_real    = clip_re.value;
         rsp_in.result_imag    = clip_im.value;
         rsp_in.divide_by_zero = 1'b0;
         rsp_in.saturated      = clip_re.sat | clip_im.sat;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Every transfer yields its result after the fixed latency
   `CAU_ASSERT_IMPL(a_latency, accept, ##LAT rsp_valid)
   // A zero divisor gives zero parts and no saturation
   `CAU_ASSERT_IMPL(a_dz_zero, rsp_valid && rsp_data.divide_by_zero,
      rsp_data.result_real == '0 && rsp_data.result_imag == '0 && !rsp_data.saturated)
   // No result without an item that entered the pipeline
   `CAU_ASSERT_IMPL(a_no_orphan, rsp_valid, $past(vd_ff[DIV_LATENCY-1]))

endmodule

`default_nettype wire

/* tb/cau_checker.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit checker
// Watches the request and result transfers, predicts each result from the
// operands with wide exact arithmetic and compares it field by field.
// ----------------------------------------------------------------------------
module cau_checker
   import cau_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic signed [191:0] MAX_PART = (192'sd1 <<< (DATA_WIDTH - 1)) - 1;
   localparam logic signed [191:0] MIN_PART = -(192'sd1 <<< (DATA_WIDTH - 1));

   rsp_type expected_results[$];

   // Clip one exact part to the data range, flag it when clipped
   function automatic logic [DATA_WIDTH-1:0] clip_exact(input logic signed [191:0] x,
                                                        inout logic flag);
      logic signed [191:0] v;
      v = x;
      if (x > MAX_PART) begin
         v    = MAX_PART;
         flag = 1'b1;
      end else if (x < MIN_PART) begin
         v    = MIN_PART;
         flag = 1'b1;
      end
      return v[DATA_WIDTH-1:0];
   endfunction

   // Compute the saturated complex result of one request
   function automatic rsp_type complex_result(input req_type r);
      logic signed [191:0] a, b, c, d, re, im, den;
      rsp_type             o;
      a = r.left_real;
      b = r.left_imag;
      c = r.right_real;
      d = r.right_imag;
      o = '0;
      case (r.operation)
         OP_ADD: begin
            re = a + c;
            im = b + d;
         end
         OP_SUB: begin
            re = a - c;
            im = b - d;
         end
         OP_MUL: begin
            // signed divide by a power of two truncates toward zero
            re = (a * c - b * d) / (192'sd1 <<< FRACTION_BITS);
            im = (a * d + b * c) / (192'sd1 <<< FRACTION_BITS);
         end
         default: begin
            den = c * c + d * d;
            if (den == 0) begin
               re = 0;
               im = 0;
               o.divide_by_zero = 1'b1;
            end else begin
               re = ((a * c + b * d) <<< FRACTION_BITS) / den;
               im = ((b * c - a * d) <<< FRACTION_BITS) / den;
            end
         end
      endcase
      o.result_real = clip_exact(re, o.saturated);
      o.result_imag = clip_exact(im, o.saturated);
      return o;
   endfunction

   assign pending_count = expected_results.size();

   // Predict on each request transfer, compare on each result transfer
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         error_count = 0;
         expected_results.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result with no request pending: %p", $time, rsp_data);
               error_count++;
            end else begin
               exp_rsp = expected_results.pop_front();
               if (rsp_data.result_real !== exp_rsp.result_real)
                  $display("%0t: result_real expected %h actual %h", $time,
                           exp_rsp.result_real, rsp_data.result_real);
               if (rsp_data.result_imag !== exp_rsp.result_imag)
                  $display("%0t: result_imag expected %h actual %h", $time,
                           exp_rsp.result_imag, rsp_data.result_imag);
               if (rsp_data.divide_by_zero !== exp_rsp.divide_by_zero)
                  $display("%0t: divide_by_zero expected %b actual %b", $time,
                           exp_rsp.divide_by_zero, rsp_data.divide_by_zero);
               if (rsp_data.saturated !== exp_rsp.saturated)
                  $display("%0t: saturated expected %b actual %b", $time,
                           exp_rsp.saturated, rsp_data.saturated);
               if (rsp_data !== exp_rsp)
                  error_count++;
            end
         end
         if (start && !busy)
            expected_results.push_back(complex_result(req_data));
      end
   end

endmodule

/* tb/tb_complex_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives directed corner operands and then random requests with random gaps,
// while the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_complex_arithmetic_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import cau_pkg::*;

   localparam int RANDOM_REQUESTS = 1500;
   localparam int IDLE_LIMIT      = 2000;
   localparam int DRAIN_CYCLES    = 60;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      error_count;
   int      pending_count;
   int      idle_cycles = 0;

   always #2 clock = ~clock;

   complex_arithmetic_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   cau_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .error_count  (error_count),
      .pending_count(pending_count)
   );

   // Watchdog: end the run after a long stretch without any transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL complex_arithmetic_unit");
            $finish;
         end
      end
   end

   // Pick an operand part: corners, small values or full random
   function automatic logic [DATA_WIDTH-1:0] pick_part();
      case ($urandom_range(0, 7))
         0:       return {1'b0, {(DATA_WIDTH-1){1'b1}}};
         1:       return {1'b1, {(DATA_WIDTH-1){1'b0}}};
         2:       return '0;
         3:       return $urandom_range(0, 8) << FRACTION_BITS;
         4:       return DATA_WIDTH'($signed($urandom_range(0, 2000)) - 1000);
         5:       return DATA_WIDTH'($urandom_range(0, 'hffff)) - 'h8000 << 8;
         default: return $urandom;
      endcase
   endfunction

   // Hold one request until it is transferred, after the given gap
   task automatic send_request(input op_type op, input logic [DATA_WIDTH-1:0] a,
                               input logic [DATA_WIDTH-1:0] b,
                               input logic [DATA_WIDTH-1:0] c,
                               input logic [DATA_WIDTH-1:0] d, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= '{op, a, b, c, d};
      do @(posedge clock); while (busy);
   endtask

   localparam logic [DATA_WIDTH-1:0] PMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] NMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic [DATA_WIDTH-1:0] ONE  = 1 << FRACTION_BITS;

   initial begin
      int gap;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, every operation, zero divisor, overflow
      send_request(OP_ADD, PMAX, NMIN, PMAX, NMIN, 0);
      send_request(OP_ADD, PMAX, '1, NMIN, 1, 0);
      send_request(OP_SUB, NMIN, PMAX, PMAX, NMIN, 0);
      send_request(OP_SUB, '0, '0, NMIN, '0, 1);
      send_request(OP_MUL, PMAX, PMAX, PMAX, NMIN, 0);
      send_request(OP_MUL, NMIN, NMIN, NMIN, NMIN, 0);
      send_request(OP_MUL, ONE, ONE, ONE, '1, 2);
      send_request(OP_MUL, '1, '0, 1, '0, 0);
      send_request(OP_DIV, ONE, ONE, '0, '0, 0);
      send_request(OP_DIV, PMAX, NMIN, '0, '0, 0);
      send_request(OP_DIV, PMAX, PMAX, 1, '0, 0);
      send_request(OP_DIV, NMIN, NMIN, '1, '1, 3);
      send_request(OP_DIV, ONE, '0, ONE, ONE, 0);
      send_request(OP_DIV, NMIN, NMIN, NMIN, NMIN, 0);
      send_request(OP_DIV, '1, '0, PMAX, PMAX, 0);

      // Random: draw a random gap before every request
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         gap = $urandom_range(0, 9);
         send_request(op_type'($urandom_range(0, 3)), pick_part(), pick_part(),
                      pick_part(), pick_part(), gap);
      end
      start <= 1'b0;

      // Drain, then let the pipeline settle
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS complex_arithmetic_unit");
      end else begin
         $display("FAIL complex_arithmetic_unit");
      end
      $finish;
   end

endmodule
